// ===== hdl/skl_pkg.sv =====
// Shared types, widths and fault codes for the skyline sweep maximum tracker.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package skl_pkg;

   // Field widths of the event and key point words.
   localparam int COORD_W  = 31;
   localparam int HEIGHT_W = 31;
   localparam int FAULT_W  = 2;

   // Default number of cells in the sorted height chain.
   localparam int MAX_ACTIVE_DEF = 64;

   // Fault codes carried with a key point.
   localparam logic [FAULT_W-1:0] FAULT_NONE     = 2'd0;
   localparam logic [FAULT_W-1:0] FAULT_OVERFLOW = 2'd1;
   localparam logic [FAULT_W-1:0] FAULT_MISSING  = 2'd2;

   // Contents of one chain cell.
   typedef struct packed {
      logic                valid;
      logic [HEIGHT_W-1:0] height;
   } cell_type;

   // Operation broadcast to every cell; apply is high when the update goes ahead.
   typedef struct packed {
      logic                apply;
      logic                start;
      logic [HEIGHT_W-1:0] height;
   } op_type;

   // Status that the chain hands back to the top level for the current event.
   typedef struct packed {
      logic [HEIGHT_W-1:0] top_height;
      logic [FAULT_W-1:0]  fault;
   } status_type;

   // One key point word.
   typedef struct packed {
      logic [COORD_W-1:0]  key_x;
      logic [HEIGHT_W-1:0] key_height;
      logic [FAULT_W-1:0]  fault;
   } result_type;

endpackage

// ===== hdl/skl_channels.sv =====
// Valid/ready channel interfaces for edge events and key points.
// Depends on skl_pkg for the field widths.
`timescale 1ns / 1ps

interface skl_req_if;
   logic                         valid;
   logic                         ready;
   logic [skl_pkg::COORD_W-1:0]  event_x;
   logic [skl_pkg::HEIGHT_W-1:0] event_height;
   logic                         is_start;
   logic                         group_end;

   modport source (output valid, event_x, event_height, is_start, group_end,
                   input ready);
   modport sink   (input valid, event_x, event_height, is_start, group_end,
                   output ready);
endinterface

interface skl_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [skl_pkg::COORD_W-1:0]  key_x;
   logic [skl_pkg::HEIGHT_W-1:0] key_height;
   logic [skl_pkg::FAULT_W-1:0]  fault;

   modport source (output valid, key_x, key_height, fault, input ready);
   modport sink   (input valid, key_x, key_height, fault, output ready);
endinterface

// ===== hdl/skl_cell.sv =====
// One cell of the sorted height chain: holds one height and shifts with its neighbors.
// Depends on skl_pkg for cell_type and op_type.
`timescale 1ns / 1ps

module skl_cell (
   input  logic              clock,
   input  logic              reset,
   input  skl_pkg::op_type   op,
   input  skl_pkg::cell_type above,
   input  logic              above_ge,
   input  skl_pkg::cell_type below,
   output skl_pkg::cell_type cur,
   output skl_pkg::cell_type nxt,
   output logic              ge,
   output logic              gt,
   output logic              match
);
   import skl_pkg::*;

   cell_type cell_ff;
   cell_type cell_in;

   // Compare the stored height with the broadcast height.
   assign ge    = cell_ff.valid && (cell_ff.height >= op.height);
   assign gt    = cell_ff.valid && (cell_ff.height >  op.height);
   assign match = cell_ff.valid && (cell_ff.height == op.height);

   // Insert opens a gap below the taller heights; delete closes the gap upward.
   always_comb begin
      cell_in = cell_ff;
      if (op.apply) begin
         if (op.start) begin
            priority if (ge) begin
               cell_in = cell_ff;
            end else if (above_ge) begin
               cell_in.valid  = 1'b1;
               cell_in.height = op.height;
            end else begin
               cell_in = above;
            end
         end else begin
            if (!gt) begin
               cell_in = below;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= cell_in.valid;
      end
      cell_ff.height <= cell_in.height;
   end

   assign cur = cell_ff;
   assign nxt = cell_in;

endmodule

// ===== hdl/skl_chain.sv =====
// Row of sorted cells, tallest height in cell zero, with full and match detection.
// Depends on skl_pkg and skl_cell.
`timescale 1ns / 1ps

module skl_chain #(
   parameter int MAX_ACTIVE = skl_pkg::MAX_ACTIVE_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         event_valid,
   input  logic                         is_start,
   input  logic [skl_pkg::HEIGHT_W-1:0] event_height,
   output skl_pkg::status_type          status
);
   import skl_pkg::*;

   cell_type                  cur   [MAX_ACTIVE];
   cell_type                  nxt   [MAX_ACTIVE];
   logic     [MAX_ACTIVE-1:0] ge;
   logic     [MAX_ACTIVE-1:0] gt;
   logic     [MAX_ACTIVE-1:0] match;
   op_type                    op;
   logic                      full;
   logic                      found;

   // The chain stays packed, so the last cell is occupied only when all are.
   assign full  = cur[MAX_ACTIVE-1].valid;
   assign found = |match;

   // An update goes ahead only when it can complete.
   always_comb begin
      op.start  = is_start;
      op.height = event_height;
      op.apply  = event_valid && (is_start ? !full : found);
   end

   // Fault of this event and the tallest height after its update.
   always_comb begin
      status.fault = FAULT_NONE;
      if (event_valid) begin
         if (is_start && full) begin
            status.fault = FAULT_OVERFLOW;
         end else if (!is_start && !found) begin
            status.fault = FAULT_MISSING;
         end
      end
      status.top_height = nxt[0].valid ? nxt[0].height : '0;
   end

   for (genvar i = 0; i < MAX_ACTIVE; i++) begin : g_cell
      cell_type above_c;
      cell_type below_c;
      logic     above_ge_c;

      if (i == 0) begin : g_first
         assign above_c    = '0;
         assign above_ge_c = 1'b1;
      end else begin : g_mid
         assign above_c    = cur[i-1];
         assign above_ge_c = ge[i-1];
      end

      if (i == MAX_ACTIVE - 1) begin : g_last
         assign below_c = '0;
      end else begin : g_inner
         assign below_c = cur[i+1];
      end

      skl_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .op       (op),
         .above    (above_c),
         .above_ge (above_ge_c),
         .below    (below_c),
         .cur      (cur[i]),
         .nxt      (nxt[i]),
         .ge       (ge[i]),
         .gt       (gt[i]),
         .match    (match[i])
      );
   end

endmodule

// ===== hdl/skl_out_queue.sv =====
// Two-word queue for key points, so events keep flowing while a word waits.
// Depends on skl_pkg for result_type.
`timescale 1ns / 1ps

module skl_out_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  skl_pkg::result_type push_word,
   output logic                space,
   output logic                out_valid,
   input  logic                out_ready,
   output skl_pkg::result_type out_word
);
   import skl_pkg::*;

   logic [1:0] count_ff;
   logic [1:0] count_in;
   result_type slot0_ff;
   result_type slot1_ff;
   logic       pop;

   assign pop       = (count_ff != 2'd0) && out_ready;
   assign space     = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_word  = slot0_ff;

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Slot zero is the head; slot one holds the second word when two wait.
   always_ff @(posedge clock) begin
      if (pop && (count_ff == 2'd2)) begin
         slot0_ff <= slot1_ff;
         if (push) begin
            slot1_ff <= push_word;
         end
      end else if (pop) begin
         if (push) begin
            slot0_ff <= push_word;
         end
      end else if (push) begin
         if (count_ff == 2'd0) begin
            slot0_ff <= push_word;
         end else begin
            slot1_ff <= push_word;
         end
      end
   end

endmodule

// ===== hdl/skyline_sweep_max_tracker.sv =====
// Skyline sweep maximum tracker: takes x-ordered building edge events and
// emits skyline key points. The block accepts one event every clock cycle:
// a start inserts its height into a chain of MAX_ACTIVE sorted cells and an
// end removes one equal height, and the tallest height is read from the
// first cell's next value. On the last event at a position a key point is
// written into a two-word output queue when the skyline height changes, and
// is registered there before it shows on the result channel. Events stall
// only when both queue words wait on the sink. Overflow of the chain and
// ends without a matching height are held as a fault code, the first one
// kept, and reported with the next key point.
`timescale 1ns / 1ps

module skyline_sweep_max_tracker #(
   parameter int MAX_ACTIVE = skl_pkg::MAX_ACTIVE_DEF
) (
   input logic        clock,
   input logic        reset,
   skl_req_if.sink    req_bus,
   skl_rsp_if.source  rsp_bus
);
   import skl_pkg::*;

   logic                accept;
   logic                space;
   logic                emit;
   status_type          status;
   logic [FAULT_W-1:0]  fault_now;
   logic [HEIGHT_W-1:0] last_height_ff;
   logic [HEIGHT_W-1:0] last_height_in;
   logic [FAULT_W-1:0]  pending_fault_ff;
   logic [FAULT_W-1:0]  pending_fault_in;
   result_type          push_word;
   result_type          out_word;

   assign req_bus.ready = space;
   assign accept        = req_bus.valid && space;

   skl_chain #(
      .MAX_ACTIVE (MAX_ACTIVE)
   ) u_chain (
      .clock        (clock),
      .reset        (reset),
      .event_valid  (accept),
      .is_start     (req_bus.is_start),
      .event_height (req_bus.event_height),
      .status       (status)
   );

   // The earliest fault since the last key point wins.
   assign fault_now = (pending_fault_ff != FAULT_NONE) ? pending_fault_ff : status.fault;
   assign emit      = accept && req_bus.group_end && (status.top_height != last_height_ff);

   always_comb begin
      push_word.key_x      = req_bus.event_x;
      push_word.key_height = status.top_height;
      push_word.fault      = fault_now;
   end

   // Track the last emitted height and the pending fault.
   always_comb begin
      last_height_in   = last_height_ff;
      pending_fault_in = pending_fault_ff;
      if (accept) begin
         if (emit) begin
            last_height_in   = status.top_height;
            pending_fault_in = FAULT_NONE;
         end else begin
            pending_fault_in = fault_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_height_ff   <= '0;
         pending_fault_ff <= FAULT_NONE;
      end else begin
         last_height_ff   <= last_height_in;
         pending_fault_ff <= pending_fault_in;
      end
   end

   skl_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_word (push_word),
      .space     (space),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_word  (out_word)
   );

   assign rsp_bus.key_x      = out_word.key_x;
   assign rsp_bus.key_height = out_word.key_height;
   assign rsp_bus.fault      = out_word.fault;

endmodule

// ===== hdl/skl_checker.sv =====
// Port-level checks for the skyline sweep maximum tracker, bound to the top level.
// Depends on skl_pkg for widths and fault codes.
`timescale 1ns / 1ps

module skl_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [skl_pkg::COORD_W-1:0]  key_x,
   input logic [skl_pkg::HEIGHT_W-1:0] key_height,
   input logic [skl_pkg::FAULT_W-1:0]  fault
);
   import skl_pkg::*;

   // Reset empties the output queue.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word shown right after reset");

   // With no word waiting the block must take events.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("event stalled while output queue is empty");

   // Only defined fault codes leave the block.
   a_fault_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (fault == FAULT_NONE || fault == FAULT_OVERFLOW ||
                     fault == FAULT_MISSING))
      else $error("undefined fault code on result word");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(key_x) &&
                                  $stable(key_height) && $stable(fault))
      else $error("result word changed while stalled");

endmodule

bind skyline_sweep_max_tracker skl_checker u_skl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .key_x      (rsp_bus.key_x),
   .key_height (rsp_bus.key_height),
   .fault      (rsp_bus.fault)
);
